// ===== src/load_cell_tare_offset_average_core_assert.svh =====
// Assertion macros for the load cell tare, offset and average core.
// Used by the top level only; needs no package.
`ifndef LOAD_CELL_TARE_OFFSET_AVERAGE_CORE_ASSERT_SVH
`define LOAD_CELL_TARE_OFFSET_AVERAGE_CORE_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define LTAO_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle.
`define LTAO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ltao_pkg.sv =====
// Package of the load cell tare, offset and average core.
// Holds field widths, register and result codes and the sequencer states.
package ltao_pkg;

    localparam int DATA_W    = 16;
    localparam int KIND_W    = 2;
    localparam int CFG_CNT_W = 6;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic signed [DATA_W-1:0] DATA_MAX = 16'sh7fff;
    localparam logic signed [DATA_W-1:0] DATA_MIN = 16'sh8000;

    typedef enum logic [0:0] {
        REG_OFFSET_PRESET = 1'b0,
        REG_AVERAGE_COUNT = 1'b1
    } t_reg;

    typedef enum logic [KIND_W-1:0] {
        KIND_MEASURE   = 2'd0,
        KIND_TARE_BUSY = 2'd1,
        KIND_TARE_DONE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

// ===== src/ltao_if.sv =====
// Valid/ready channel interfaces for sample items and result items.
// Depends on ltao_pkg for the field widths.
interface ltao_in_if import ltao_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     func;
    logic signed [DATA_W-1:0] sample;

    modport source(output valid, output func, output sample, input ready);
    modport sink(input valid, input func, input sample, output ready);
endinterface

interface ltao_out_if import ltao_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic [KIND_W-1:0]        kind;

    modport source(output valid, output value, output kind, input ready);
    modport sink(input valid, input value, input kind, output ready);
endinterface

// ===== src/ltao_div.sv =====
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Standalone; used by the top level for the average and the tare offset.
module ltao_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 7
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0]        i_den,
    output logic                    o_done,
    output logic signed [NUM_W-1:0] o_quo
);
    localparam int CW = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic             r_neg;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [NUM_W-1:0] w_mag;
    logic [DEN_W:0]   w_rem_sh;
    logic [DEN_W:0]   w_rem_sub;
    logic             w_bit;

    assign w_mag     = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
    assign w_rem_sh  = {r_rem, r_quo[NUM_W-1]};
    assign w_bit     = (w_rem_sh >= {1'b0, r_den});
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], w_bit};
            r_rem <= w_bit ? w_rem_sub[DEN_W-1:0] : w_rem_sh[DEN_W-1:0];
        end else if (i_start) begin
            r_quo <= w_mag;
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[NUM_W-1];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

// ===== src/load_cell_tare_offset_average_core.sv =====
// Load cell conditioner: offset subtraction with clipping, moving average over a
// ring memory, and a tare that averages TARE_SAMPLES raw samples into a new offset.
// One item at a time: with averaging off or a tare in progress, IDLE then OUT; the tare
// item that completes goes through DIV, and an item with N entries averaged through SUM
// (the memory read sweep) and DIV (the serial divider); a stalled output adds its stall.
// Synchronous reset clears the control state; ring data and result registers are not reset.
`include "load_cell_tare_offset_average_core_assert.svh"

module load_cell_tare_offset_average_core import ltao_pkg::*; #(
    parameter int RING_DEPTH   = 32,
    parameter int TARE_SAMPLES = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ltao_in_if.sink              i_in,
    ltao_out_if.source           o_out,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);
    localparam int IDX_W     = $clog2(RING_DEPTH);
    localparam int CNT_W     = IDX_W + 1;
    localparam int SUM_W     = DATA_W + IDX_W + 1;
    localparam int TC_W      = $clog2(TARE_SAMPLES + 1);
    localparam int TSUM_W    = DATA_W + TC_W + 1;
    localparam int DIV_NUM_W = (SUM_W > TSUM_W) ? SUM_W : TSUM_W;
    localparam int DIV_DEN_W = (CNT_W > TC_W) ? CNT_W : TC_W;

    // Configuration registers.
    logic signed [DATA_W-1:0] r_offset_preset;
    logic [CFG_CNT_W-1:0]     r_avg_cnt;

    // Tare state.
    logic signed [TSUM_W-1:0] r_tare_sum;
    logic [TC_W-1:0]          r_tare_cnt;
    logic signed [DATA_W-1:0] r_tared_offset;
    logic                     r_tare_active;

    // Ring memory with one valid bit per entry; an entry not yet written reads as zero.
    logic signed [DATA_W-1:0] r_ring [RING_DEPTH];
    logic [RING_DEPTH-1:0]    r_ring_vld;
    logic [IDX_W-1:0]         r_ring_idx;
    logic signed [DATA_W-1:0] r_rd_data;
    logic                     r_rd_vld;

    // Sequencer.
    t_state                   r_state;
    t_state                   n_state;
    logic [CNT_W-1:0]         r_rd_addr;
    logic                     r_rd_pend;
    logic signed [SUM_W-1:0]  r_acc;
    logic                     r_is_tare;
    logic signed [DATA_W-1:0] r_res;
    t_kind                    r_res_kind;

    // Output register.
    logic                     r_out_vld;
    logic signed [DATA_W-1:0] r_out_value;
    t_kind                    r_out_kind;

    logic                     w_accept;
    logic                     w_in_ready;
    logic                     w_div_start;
    logic                     w_out_load;
    logic                     w_issue;
    logic [CNT_W-1:0]         w_cnt;
    logic signed [DATA_W-1:0] w_off;
    logic signed [DATA_W:0]   w_diff;
    logic signed [DATA_W-1:0] w_clip;
    logic [CNT_W-1:0]         w_idx_inc;
    logic [IDX_W-1:0]         w_idx_nx;
    logic signed [TSUM_W-1:0] w_tsum_nx;
    logic [TC_W-1:0]          w_tcnt_nx;
    logic                     w_tare_end;
    logic                     w_ring_we;
    logic signed [DIV_NUM_W-1:0] w_div_num;
    logic [DIV_DEN_W-1:0]     w_div_den;
    logic                     w_div_done;
    logic signed [DIV_NUM_W-1:0] w_div_quo;
    logic                     w_cfg_we;

    assign w_cnt     = CNT_W'(r_avg_cnt);
    assign w_accept  = i_in.valid && w_in_ready;
    assign w_off     = r_tare_active ? r_tared_offset : r_offset_preset;
    assign w_diff    = (DATA_W + 1)'(i_in.sample) - (DATA_W + 1)'(w_off);
    assign w_clip    = (w_diff > (DATA_W + 1)'(DATA_MAX)) ? DATA_MAX :
                       (w_diff < (DATA_W + 1)'(DATA_MIN)) ? DATA_MIN : w_diff[DATA_W-1:0];
    assign w_idx_inc = CNT_W'(r_ring_idx) + CNT_W'(1);
    assign w_idx_nx  = (w_idx_inc >= w_cnt) ? '0 : w_idx_inc[IDX_W-1:0];
    assign w_tsum_nx = r_tare_sum + TSUM_W'(i_in.sample);
    assign w_tcnt_nx = r_tare_cnt + TC_W'(1);
    assign w_tare_end = (w_tcnt_nx == TC_W'(TARE_SAMPLES));
    assign w_ring_we = w_accept && !i_in.func && (w_cnt != '0);
    assign w_issue   = (r_rd_addr < w_cnt);

    assign w_div_num = (r_state == ST_SUM) ? DIV_NUM_W'(r_acc) : DIV_NUM_W'(w_tsum_nx);
    assign w_div_den = (r_state == ST_SUM) ? DIV_DEN_W'(w_cnt) : DIV_DEN_W'(TARE_SAMPLES);

    ltao_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    always_comb begin
        n_state     = r_state;
        w_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in.valid) begin
                    if (i_in.func) begin
                        if (w_tare_end) begin
                            w_div_start = 1'b1;
                            n_state     = ST_DIV;
                        end else begin
                            n_state = ST_OUT;
                        end
                    end else if (w_cnt != '0) begin
                        n_state = ST_SUM;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_SUM: begin
                if (!w_issue && !r_rd_pend) begin
                    w_div_start = 1'b1;
                    n_state     = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_vld || o_out.ready) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Ring memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_ring_we) begin
            r_ring[w_idx_nx] <= w_clip;
        end
        r_rd_data <= r_ring[r_rd_addr[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_vld <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (w_ring_we) begin
                r_ring_vld[w_idx_nx] <= 1'b1;
            end
            r_rd_vld <= r_ring_vld[r_rd_addr[IDX_W-1:0]];
        end
    end

    // Item state: ring index, tare accumulation, sum sweep and tared offset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_idx     <= '0;
            r_tare_sum     <= '0;
            r_tare_cnt     <= '0;
            r_tared_offset <= '0;
            r_tare_active  <= 1'b0;
            r_rd_addr      <= '0;
            r_rd_pend      <= 1'b0;
            r_is_tare      <= 1'b0;
        end else begin
            if (w_accept) begin
                r_is_tare <= i_in.func;
                r_rd_addr <= '0;
                r_rd_pend <= 1'b0;
                if (i_in.func) begin
                    if (w_tare_end) begin
                        r_tare_sum <= '0;
                        r_tare_cnt <= '0;
                    end else begin
                        r_tare_sum <= w_tsum_nx;
                        r_tare_cnt <= w_tcnt_nx;
                    end
                end else if (w_cnt != '0) begin
                    r_ring_idx <= w_idx_nx;
                end
            end
            if (r_state == ST_SUM) begin
                r_rd_pend <= w_issue;
                if (w_issue) begin
                    r_rd_addr <= r_rd_addr + CNT_W'(1);
                end
            end
            if (r_state == ST_DIV && w_div_done && r_is_tare) begin
                r_tared_offset <= w_div_quo[DATA_W-1:0];
                r_tare_active  <= 1'b1;
            end
            if (w_cfg_we && paddr[2] == REG_OFFSET_PRESET) begin
                r_tare_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_acc <= '0;
            if (i_in.func) begin
                r_res      <= '0;
                r_res_kind <= KIND_TARE_BUSY;
            end else begin
                r_res      <= w_clip;
                r_res_kind <= KIND_MEASURE;
            end
        end else if (r_state == ST_SUM && r_rd_pend && r_rd_vld) begin
            r_acc <= r_acc + SUM_W'(r_rd_data);
        end else if (r_state == ST_DIV && w_div_done) begin
            r_res <= w_div_quo[DATA_W-1:0];
            if (r_is_tare) begin
                r_res_kind <= KIND_TARE_DONE;
            end
        end
    end

    // Output register parts the result side from the sample side.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_value <= r_res;
            r_out_kind  <= r_res_kind;
        end
    end

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = r_out_vld;
    assign o_out.value = r_out_value;
    assign o_out.kind  = r_out_kind;

    // Configuration port.
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_preset <= '0;
            r_avg_cnt       <= '0;
        end else if (w_cfg_we) begin
            case (t_reg'(paddr[2]))
                REG_OFFSET_PRESET: begin
                    r_offset_preset <= pwdata[DATA_W-1:0];
                end
                REG_AVERAGE_COUNT: begin
                    // A count beyond the ring depth is dropped.
                    if (32'(pwdata[CFG_CNT_W-1:0]) <= 32'(RING_DEPTH)) begin
                        r_avg_cnt <= pwdata[CFG_CNT_W-1:0];
                    end
                end
                default: begin
                    r_avg_cnt <= r_avg_cnt;
                end
            endcase
        end
    end

    always_comb begin
        case (t_reg'(paddr[2]))
            REG_OFFSET_PRESET: prdata = PDATA_W'(r_offset_preset);
            REG_AVERAGE_COUNT: prdata = PDATA_W'(r_avg_cnt);
            default:           prdata = '0;
        endcase
    end

    `LTAO_ASSERT_NOW(a_idx_in_range, i_clk, i_rst_n, (r_state == ST_SUM),
        (CNT_W'(r_ring_idx) < w_cnt), "ring index beyond average count")
    `LTAO_ASSERT_NOW(a_div_done_state, i_clk, i_rst_n, w_div_done,
        (r_state == ST_DIV), "divider finished outside the divide phase")
    `LTAO_ASSERT_NOW(a_tare_cnt_range, i_clk, i_rst_n, 1'b1,
        (r_tare_cnt < TC_W'(TARE_SAMPLES)), "tare count reached its limit")
    `LTAO_ASSERT_NEXT(a_direct_result, i_clk, i_rst_n,
        (w_accept && !i_in.func && w_cnt == '0), (r_state == ST_OUT),
        "unaveraged measure item did not go straight to output")

endmodule

// ===== verif/tb_load_cell_tare_offset_average_core.sv =====
// Testbench for load_cell_tare_offset_average_core: directed table then random phases.
// A local predictor checks every result item in order; relies on ltao_pkg and ltao_if.
// Register writes go through the APB port only while no result item is outstanding.
module tb_load_cell_tare_offset_average_core;
    import ltao_pkg::*;

    localparam int RING_ENTRIES     = 32;
    localparam int TARE_LEN         = 64;
    localparam int RANDOM_ITEMS     = 1850;
    localparam int HOLD_AT_ITEM     = 400;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int SETTLE_CYCLES    = 4;
    localparam int END_WAIT_CYCLES  = 80;
    localparam int CYCLE_LIMIT      = 2000000;
    localparam int DIRECTED_ROWS    = 25;

    localparam logic FUNC_MEASURE = 1'b0;
    localparam logic FUNC_TARE    = 1'b1;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        t_kind                    kind;
    } t_reading;

    typedef struct packed {
        logic                     is_cfg;
        t_reg                     reg_sel;
        logic                     func;
        logic [PDATA_W-1:0]       data;
        logic                     typed;
        logic signed [DATA_W-1:0] exp_value;
        t_kind                    exp_kind;
    } t_step;

    // Rows with typed set carry a result that follows directly from the rules.
    t_step directed_plan [DIRECTED_ROWS] = '{
        '{1'b0, REG_OFFSET_PRESET, FUNC_MEASURE, 32'h0000_0000, 1'b1, 16'sh0000, KIND_MEASURE},
        '{1'b0, REG_OFFSET_PRESET, FUNC_MEASURE, 32'h0000_7fff, 1'b1, 16'sh7fff, KIND_MEASURE},
        '{1'b0, REG_OFFSET_PRESET, FUNC_MEASURE, 32'h0000_8000, 1'b1, 16'sh8000, KIND_MEASURE},
        '{1'b0, REG_OFFSET_PRESET, FUNC_TARE,    32'h0000_7fff, 1'b1, 16'sh0000, KIND_TARE_BUSY},
        '{1'b0, REG_OFFSET_PRESET, FUNC_MEASURE, 32'h0000_1234, 1'b1, 16'sh1234, KIND_MEASURE},
        '{1'b1, REG_OFFSET_PRESET, FUNC_MEASURE, 32'hffff_8000, 1'b0, 16'sh0000, KIND_MEASURE},
        '{1'b0, REG_OFFSET_PRESET, FUNC_MEASURE, 32'h0000_7fff, 1'b1, 16'sh7fff, KIND_MEASURE},
        '{1'b0, REG_OFFSET_PRESET, FUNC_MEASURE, 32'h0000_8000, 1'b1, 16'sh0000, KIND_MEASURE},
        '{1'b0, REG_OFFSET_PRESET, FUNC_TARE,    32'h0000_8000, 1'b1, 16'sh0000, KIND_TARE_BUSY},
        '{1'b1, REG_OFFSET_PRESET, FUNC_MEASURE, 32'h0000_7fff, 1'b0, 16'sh0000, KIND_MEASURE},
        '{1'b0, REG_OFFSET_PRESET, FUNC_MEASURE, 32'h0000_8000, 1'b1, 16'sh8000, KIND_MEASURE},
        '{1'b0, REG_OFFSET_PRESET, FUNC_MEASURE, 32'h0000_0001, 1'b1, 16'sh8002, KIND_MEASURE},
        '{1'b1, REG_AVERAGE_COUNT, FUNC_MEASURE, 32'h0000_0021, 1'b0, 16'sh0000, KIND_MEASURE},
        '{1'b0, REG_OFFSET_PRESET, FUNC_MEASURE, 32'h0000_0064, 1'b1, 16'sh8065, KIND_MEASURE},
        '{1'b1, REG_AVERAGE_COUNT, FUNC_MEASURE, 32'h0000_0020, 1'b0, 16'sh0000, KIND_MEASURE},
        '{1'b0, REG_OFFSET_PRESET, FUNC_MEASURE, 32'h0000_7fff, 1'b0, 16'sh0000, KIND_MEASURE},
        '{1'b0, REG_OFFSET_PRESET, FUNC_MEASURE, 32'h0000_8000, 1'b0, 16'sh0000, KIND_MEASURE},
        '{1'b1, REG_AVERAGE_COUNT, FUNC_MEASURE, 32'h0000_003f, 1'b0, 16'sh0000, KIND_MEASURE},
        '{1'b0, REG_OFFSET_PRESET, FUNC_MEASURE, 32'h0000_4000, 1'b0, 16'sh0000, KIND_MEASURE},
        '{1'b1, REG_AVERAGE_COUNT, FUNC_MEASURE, 32'h0000_0001, 1'b0, 16'sh0000, KIND_MEASURE},
        '{1'b0, REG_OFFSET_PRESET, FUNC_MEASURE, 32'h0000_0005, 1'b0, 16'sh0000, KIND_MEASURE},
        '{1'b1, REG_OFFSET_PRESET, FUNC_MEASURE, 32'h0000_0000, 1'b0, 16'sh0000, KIND_MEASURE},
        '{1'b1, REG_AVERAGE_COUNT, FUNC_MEASURE, 32'h0000_0000, 1'b0, 16'sh0000, KIND_MEASURE},
        '{1'b0, REG_OFFSET_PRESET, FUNC_MEASURE, 32'h0000_ffff, 1'b1, 16'shffff, KIND_MEASURE},
        '{1'b0, REG_OFFSET_PRESET, FUNC_TARE,    32'h0000_ffff, 1'b1, 16'sh0000, KIND_TARE_BUSY}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    ltao_in_if  in_if();
    ltao_out_if out_if();

    load_cell_tare_offset_average_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state, kept in step with the block.
    logic signed [DATA_W-1:0] ring_mem [RING_ENTRIES];
    int                       ring_pos;
    logic signed [22:0]       tare_acc;
    logic [6:0]               tare_cnt;
    logic signed [DATA_W-1:0] tared_offset;
    logic                     use_tared;
    logic signed [DATA_W-1:0] preset_offset;
    logic [CFG_CNT_W-1:0]     average_n;

    t_reading pending_readings [$];
    int       error_count;
    int       items_sent;
    int       register_writes;
    int       tares_completed;
    int       burst_left;
    int       cycle_count;
    logic     hold_req;

    function automatic logic signed [DATA_W-1:0] sat16(input int v);
        if (v > 32767) begin
            return DATA_MAX;
        end
        if (v < -32768) begin
            return DATA_MIN;
        end
        return 16'(v);
    endfunction

    function automatic t_reading predict_reading(input logic f, input logic signed [DATA_W-1:0] s);
        t_reading                 r;
        logic signed [DATA_W-1:0] diff;
        int                       acc;
        int                       i;
        if (f == FUNC_MEASURE) begin
            diff = sat16(int'(s) - int'(use_tared ? tared_offset : preset_offset));
            if (average_n != 0) begin
                // The index moves before the store, so a stale index wraps here.
                ring_pos++;
                if (ring_pos >= int'(average_n)) begin
                    ring_pos = 0;
                end
                ring_mem[ring_pos] = diff;
                acc = 0;
                for (i = 0; i < int'(average_n); i++) begin
                    acc += int'(ring_mem[i]);
                end
                r.value = 16'(acc / int'(average_n));
            end else begin
                r.value = diff;
            end
            r.kind = KIND_MEASURE;
        end else begin
            tare_acc = tare_acc + 23'(s);
            tare_cnt++;
            if (tare_cnt >= TARE_LEN) begin
                tared_offset = sat16(int'(tare_acc) / TARE_LEN);
                use_tared    = 1'b1;
                tare_acc     = '0;
                tare_cnt     = '0;
                r.value      = tared_offset;
                r.kind       = KIND_TARE_DONE;
            end else begin
                r.value = '0;
                r.kind  = KIND_TARE_BUSY;
            end
        end
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_sample(input logic f, input logic signed [DATA_W-1:0] s,
                               input logic typed, input t_reading typed_result);
        t_reading predicted;
        int       gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.func   <= f;
        in_if.sample <= s;
        do begin
            @(posedge i_clk);
        end while (!in_if.ready);
        predicted = predict_reading(f, s);
        pending_readings.push_back(typed ? typed_result : predicted);
        items_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    // Lowers valid and waits until every result item has come out.
    task automatic settle_block();
        in_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_readings.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input t_reg r_sel, input logic [PDATA_W-1:0] d);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(r_sel));
        pwdata  <= d;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (r_sel == REG_OFFSET_PRESET) begin
            preset_offset = d[DATA_W-1:0];
            use_tared     = 1'b0;
        end else if (d[CFG_CNT_W-1:0] <= RING_ENTRIES) begin
            average_n = d[CFG_CNT_W-1:0];
        end
        register_writes++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d result items outstanding",
                 cycle_count, pending_readings.size());
        $display("Verification failed");
        $finish;
    end

    // Output side: stall pattern changes in stretches, with one long hold on request.
    initial begin
        int   mode;
        int   stretch_left;
        int   tick;
        logic rdy;
        out_if.ready = 1'b0;
        stretch_left = 0;
        mode         = 0;
        tick         = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                if (stretch_left == 0) begin
                    mode         = $urandom_range(0, 3);
                    stretch_left = $urandom_range(8, 120);
                end
                stretch_left--;
                tick++;
                case (mode)
                    0:       rdy = 1'b1;
                    1:       rdy = 1'($urandom_range(0, 1));
                    2:       rdy = ($urandom_range(0, 7) == 0);
                    default: rdy = ((tick % 5) != 0);
                endcase
                out_if.ready <= rdy;
            end
        end
    end

    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_readings.size() == 0) begin
                $display("%0t: result item with nothing expected: value %0d kind %0d",
                         $time, out_if.value, out_if.kind);
                error_count++;
            end else begin
                want = pending_readings.pop_front();
                if (out_if.value !== want.value) begin
                    $display("%0t: value mismatch, expected %0d actual %0d",
                             $time, want.value, out_if.value);
                    error_count++;
                end
                if (out_if.kind !== want.kind) begin
                    $display("%0t: kind mismatch, expected %0d actual %0d",
                             $time, want.kind, out_if.kind);
                    error_count++;
                end
                if (want.kind == KIND_TARE_DONE) begin
                    tares_completed++;
                end
            end
        end
    end

    initial begin
        int                       row;
        int                       random_sent;
        int                       phase_len;
        int                       k;
        int                       tare_pct;
        int                       tare_style;
        int                       centre;
        int                       load_centre;
        int                       choice;
        logic                     f;
        logic signed [DATA_W-1:0] s;
        logic signed [DATA_W-1:0] v16;
        logic [PDATA_W-1:0]       wdata;
        t_reading                 typed_res;

        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.func   = FUNC_MEASURE;
        in_if.sample = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        hold_req     = 1'b0;
        for (k = 0; k < RING_ENTRIES; k++) begin
            ring_mem[k] = '0;
        end
        ring_pos        = 0;
        tare_acc        = '0;
        tare_cnt        = '0;
        tared_offset    = '0;
        use_tared       = 1'b0;
        preset_offset   = '0;
        average_n       = '0;
        error_count     = 0;
        items_sent      = 0;
        register_writes = 0;
        tares_completed = 0;
        burst_left      = 0;
        random_sent     = 0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (row = 0; row < DIRECTED_ROWS; row++) begin
            if (directed_plan[row].is_cfg) begin
                settle_block();
                write_register(directed_plan[row].reg_sel, directed_plan[row].data);
            end else begin
                typed_res.value = directed_plan[row].exp_value;
                typed_res.kind  = directed_plan[row].exp_kind;
                send_sample(directed_plan[row].func, directed_plan[row].data[DATA_W-1:0],
                            directed_plan[row].typed, typed_res);
            end
        end

        // Random phases: settings written at random, then a run that is either mostly tares
        // (random, around some level or at an extreme) or mostly measurements around a load level.
        typed_res = '0;
        while (random_sent < RANDOM_ITEMS) begin
            settle_block();
            if ($urandom_range(0, 9) < 6) begin
                case ($urandom_range(0, 4))
                    0:       v16 = DATA_MIN;
                    1:       v16 = DATA_MAX;
                    2:       v16 = sat16(int'($urandom_range(0, 600)) - 300);
                    default: v16 = 16'($urandom());
                endcase
                write_register(REG_OFFSET_PRESET, 32'(v16));
            end
            if ($urandom_range(0, 9) < 7) begin
                case ($urandom_range(0, 9))
                    0:       wdata = 0;
                    1:       wdata = 1;
                    2:       wdata = RING_ENTRIES;
                    3:       wdata = $urandom_range(RING_ENTRIES + 1, 63);
                    4:       wdata = $urandom_range(13, RING_ENTRIES - 1);
                    default: wdata = $urandom_range(2, 12);
                endcase
                write_register(REG_AVERAGE_COUNT, wdata);
            end
            phase_len   = $urandom_range(20, 120);
            tare_pct    = ($urandom_range(0, 2) == 0) ? 90 : 5;
            tare_style  = $urandom_range(0, 3);
            centre      = int'($urandom_range(0, 40000)) - 20000;
            load_centre = int'($urandom_range(0, 60000)) - 30000;
            for (k = 0; k < phase_len && random_sent < RANDOM_ITEMS; k++) begin
                if ($urandom_range(0, 99) < tare_pct) begin
                    f = FUNC_TARE;
                    case (tare_style)
                        0:       s = 16'($urandom());
                        1:       s = sat16(centre + int'($urandom_range(0, 600)) - 300);
                        2:       s = DATA_MAX;
                        default: s = DATA_MIN;
                    endcase
                end else begin
                    f      = FUNC_MEASURE;
                    choice = $urandom_range(0, 9);
                    if (choice == 0) begin
                        s = $urandom_range(0, 1) ? DATA_MAX : DATA_MIN;
                    end else if (choice < 6) begin
                        s = sat16(load_centre + int'($urandom_range(0, 2000)) - 1000);
                    end else begin
                        s = 16'($urandom());
                    end
                end
                if (random_sent == HOLD_AT_ITEM) begin
                    hold_req = 1'b1;
                end
                send_sample(f, s, 1'b0, typed_res);
                random_sent++;
            end
        end

        settle_block();
        repeat (END_WAIT_CYCLES) @(negedge i_clk);

        $display("Run covered %0d sample items, %0d completed tares and %0d register writes.",
                 items_sent, tares_completed, register_writes);
        $display("Windows 0 to 32, oversized counts, offset extremes and a long output hold.");
        if (error_count == 0 && pending_readings.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
